/* hdl/frp_pkg.sv */
package frp_pkg;

    localparam logic [7:0] CH_U          = 8'h55;
    localparam logic [7:0] CH_N          = 8'h4E;
    localparam logic [7:0] CH_E          = 8'h45;
    localparam logic [7:0] CH_R          = 8'h52;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] TIMEOUT_RESET = 8'd5;
    localparam logic [7:0] HEADER_XOR    = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT_U  = 3'd0,
        PH_WAIT_N  = 3'd1,
        PH_WAIT_E  = 3'd2,
        PH_WAIT_R  = 3'd3,
        PH_LENGTH  = 3'd4,
        PH_COLON   = 3'd5,
        PH_PAYLOAD = 3'd6
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       is_command_id;
        logic       frame_end;
        logic       checksum_ok;
        logic       timed_out;
    } t_result;

endpackage

/* hdl/frp_in_stage.sv */
module frp_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  frp_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output frp_pkg::t_item o_item
);
    import frp_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* hdl/frp_parser.sv */
module frp_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_advance,
    input  frp_pkg::t_item   i_item,
    output frp_pkg::t_result o_result
);
    import frp_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_remain, n_remain;
    logic [7:0] r_xor, n_xor;
    logic [7:0] r_tleft, n_tleft;
    logic       r_expect, n_expect;
    logic [7:0] r_tticks;
    t_result    res;

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tticks <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_tticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT_U;
            r_remain <= '0;
            r_xor    <= '0;
            r_tleft  <= '0;
            r_expect <= 1'b0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_xor    <= n_xor;
            r_tleft  <= n_tleft;
            r_expect <= n_expect;
        end
    end

    always_comb begin
        logic [7:0] b;
        b        = i_item.rx_byte;
        n_phase  = r_phase;
        n_remain = r_remain;
        n_xor    = r_xor;
        n_tleft  = r_tleft;
        n_expect = r_expect;
        res      = '0;
        if (i_item.kind == KIND_TICK) begin
            if (r_phase != PH_WAIT_U) begin
                n_tleft = r_tleft - 8'd1;
                if (n_tleft == 8'd0) begin
                    n_phase       = PH_WAIT_U;
                    n_expect      = 1'b0;
                    res.timed_out = 1'b1;
                end
            end
        end else begin
            case (r_phase)
                PH_WAIT_U: begin
                    if (b == CH_U) begin
                        n_phase = PH_WAIT_N;
                        n_tleft = r_tticks;
                    end
                end
                PH_WAIT_N: begin
                    if (b == CH_N) begin
                        n_phase = PH_WAIT_E;
                    end else if (b != CH_U) begin
                        n_phase = PH_WAIT_U;
                    end
                end
                PH_WAIT_E, PH_WAIT_R, PH_COLON: begin
                    if (r_phase == PH_WAIT_E && b == CH_E) begin
                        n_phase = PH_WAIT_R;
                    end else if (r_phase == PH_WAIT_R && b == CH_R) begin
                        n_phase = PH_LENGTH;
                    end else if (r_phase == PH_COLON && b == CH_COLON) begin
                        n_phase  = PH_PAYLOAD;
                        n_xor    = HEADER_XOR ^ r_remain;
                        n_expect = 1'b1;
                    end else if (b == CH_U) begin
                        // byte re-examined as a new start
                        n_phase = PH_WAIT_N;
                        n_tleft = r_tticks;
                    end else begin
                        n_phase = PH_WAIT_U;
                    end
                end
                PH_LENGTH: begin
                    n_remain = b;
                    n_phase  = PH_COLON;
                end
                PH_PAYLOAD: begin
                    n_remain = r_remain - 8'd1;
                    if (n_remain != 8'd0) begin
                        n_xor             = r_xor ^ b;
                        res.payload_valid = 1'b1;
                        res.payload_byte  = b;
                        res.is_command_id = r_expect;
                        n_expect          = 1'b0;
                    end else begin
                        n_phase         = PH_WAIT_U;
                        n_expect        = 1'b0;
                        res.frame_end   = 1'b1;
                        res.checksum_ok = (b == r_xor);
                    end
                end
                default: begin
                    n_phase = PH_WAIT_U;
                end
            endcase
        end
    end

endmodule

/* hdl/frp_out_stage.sv */
module frp_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  frp_pkg::t_result i_result,
    output logic            o_valid,
    input  logic            i_ready,
    output frp_pkg::t_result o_result
);
    import frp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

/* hdl/framed_packet_receiver.sv */
// channel   direction  handshake                   payload
// in        sink       i_in_valid / o_in_ready     i_kind, i_rx_byte
// out       source     o_out_valid / i_out_ready   o_payload_valid .. o_timed_out
// cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_timeout_ticks
//
// one beat in and one beat out per cycle while the output is not stalled; input
// register, then parse logic into the result register
// parser state advances when a beat moves from the input to the result register
// a stalled output holds both registers; cfg is always ready
// synchronous active-low reset: phase waiting for U, timeout_ticks 5
module framed_packet_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_payload_valid,
    output logic [7:0] o_payload_byte,
    output logic       o_is_command_id,
    output logic       o_frame_end,
    output logic       o_checksum_ok,
    output logic       o_timed_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_timeout_ticks
);
    import frp_pkg::*;

    t_item   in_item, s1_item;
    t_result s2_in, s2_out;
    logic    s1_valid, s2_ready;

    assign in_item.kind    = i_kind;
    assign in_item.rx_byte = i_rx_byte;
    assign o_cfg_ready     = 1'b1;

    frp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (s1_valid),
        .i_ready (s2_ready),
        .o_item  (s1_item)
    );

    frp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_timeout_ticks),
        .i_advance   (s1_valid && s2_ready),
        .i_item      (s1_item),
        .o_result    (s2_in)
    );

    frp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .o_ready  (s2_ready),
        .i_result (s2_in),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (s2_out)
    );

    assign o_payload_valid = s2_out.payload_valid;
    assign o_payload_byte  = s2_out.payload_byte;
    assign o_is_command_id = s2_out.is_command_id;
    assign o_frame_end     = s2_out.frame_end;
    assign o_checksum_ok   = s2_out.checksum_ok;
    assign o_timed_out     = s2_out.timed_out;

endmodule
